[src/gvns_pkg.sv]
`default_nettype none

package gvns_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 4096;
    localparam int COL_W       = 8;
    localparam int ROW_W       = 12;
    localparam int SLOT_W      = COL_W + 1;
    localparam int UNIT        = 16384;

    // register indexes of the configuration channel
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    // item kinds on s_tuser
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef logic signed [31:0] pos_t;

    // x in the lowest bits, as on the stream
    typedef struct packed {
        pos_t z;
        pos_t y;
        pos_t x;
    } vec_t;

    // one stencil job from the front to the back
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             has_r;
        logic             has_l;
        logic             has_d;
        logic             has_u;
        vec_t             c;
        vec_t             r;
        vec_t             l;
        vec_t             d;
        vec_t             u;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_RC,
        F_RR,
        F_RL,
        F_RU,
        F_FIN
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_VEC,
        B_MUL,
        B_MAG,
        B_SCALE,
        B_SQ,
        B_SQRT,
        B_DSET,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

[src/gvns_front.sv]
`default_nettype none

module gvns_front import gvns_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        s_tuser,
    input  wire logic [95:0] s_tdata,
    output job_t             job,
    output logic             job_valid,
    input  wire logic        job_ready
);

    front_state_t state_reg, state_next;

    logic [8:0]       cols_cfg_reg;
    logic [12:0]      rows_cfg_reg;
    logic [COL_W-1:0] col_idx_reg, col_idx_next;
    logic [ROW_W-1:0] row_idx_reg, row_idx_next;
    logic [COL_W-1:0] drain_idx_reg, drain_idx_next;
    logic             full_reg, full_next;

    logic             is_drain_reg;
    vec_t             pos_reg;
    logic [ROW_W-1:0] jr_reg;
    logic [COL_W-1:0] jc_reg;
    vec_t             c_reg, r_reg, l_reg;

    logic [95:0]       mem [2*MAX_COLUMNS];
    logic [95:0]       rdata_reg;
    logic              mem_we, mem_re;
    logic [SLOT_W-1:0] waddr, raddr;
    logic [95:0]       wdata;

    logic [8:0]  cols_eff;
    logic [12:0] rows_eff;
    logic        accept, is_push, take, col_last, row_last, drain_last;
    logic        adv_push, adv_drain, start_job;

    // clamp the sizes
    always_comb begin
        cols_eff = cols_cfg_reg;
        if (cols_cfg_reg < 9'd2) cols_eff = 9'd2;
        if (cols_cfg_reg > 9'(MAX_COLUMNS)) cols_eff = 9'(MAX_COLUMNS);
        rows_eff = rows_cfg_reg;
        if (rows_cfg_reg < 13'd2) rows_eff = 13'd2;
        if (rows_cfg_reg > 13'(MAX_ROWS)) rows_eff = 13'(MAX_ROWS);
    end

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= 9'(MAX_COLUMNS);
            rows_cfg_reg <= 13'd256;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_COLUMNS) cols_cfg_reg <= cfg_data[8:0];
            else rows_cfg_reg <= cfg_data;
        end
    end

    assign s_tready   = (state_reg == F_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign is_push    = (s_tuser == ACT_PUSH);
    assign take       = is_push ? !full_reg : full_reg;
    assign col_last   = ({1'b0, col_idx_reg} + 9'd1) >= cols_eff;
    assign row_last   = ({1'b0, row_idx_reg} + 13'd1) >= rows_eff;
    assign drain_last = ({1'b0, drain_idx_reg} + 9'd1) >= cols_eff;
    assign start_job  = accept && take && (!is_push || row_idx_reg != '0);
    assign adv_push   = (accept && take && is_push && row_idx_reg == '0)
                     || (state_reg == F_FIN && job_ready && !is_drain_reg);
    assign adv_drain  = (state_reg == F_FIN && job_ready && is_drain_reg);

    // next state and store access
    always_comb begin
        state_next = state_reg;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        raddr      = {jr_reg[0], jc_reg};
        waddr      = {row_idx_reg[0], col_idx_reg};
        wdata      = pos_reg;
        job_valid  = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (accept && take && is_push && row_idx_reg == '0) begin
                    mem_we = 1'b1;
                    wdata  = s_tdata;
                end
                if (start_job) state_next = F_RC;
            end
            F_RC: begin
                mem_re     = 1'b1;
                state_next = F_RR;
            end
            F_RR: begin
                mem_re     = 1'b1;
                raddr      = {jr_reg[0], jc_reg + 8'd1};
                state_next = F_RL;
            end
            F_RL: begin
                mem_re     = 1'b1;
                raddr      = {jr_reg[0], jc_reg - 8'd1};
                state_next = F_RU;
            end
            F_RU: begin
                mem_re     = 1'b1;
                raddr      = {~jr_reg[0], jc_reg};
                state_next = F_FIN;
            end
            F_FIN: begin
                job_valid = 1'b1;
                if (job_ready) begin
                    mem_we     = !is_drain_reg;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // advance the grid indices
    always_comb begin
        col_idx_next   = col_idx_reg;
        row_idx_next   = row_idx_reg;
        drain_idx_next = drain_idx_reg;
        full_next      = full_reg;
        if (adv_push) begin
            if (col_last) begin
                col_idx_next = '0;
                if (row_last) begin
                    full_next      = 1'b1;
                    drain_idx_next = '0;
                end else begin
                    row_idx_next = row_idx_reg + 12'd1;
                end
            end else begin
                col_idx_next = col_idx_reg + 8'd1;
            end
        end else if (adv_drain) begin
            if (drain_last) begin
                row_idx_next   = '0;
                col_idx_next   = '0;
                drain_idx_next = '0;
                full_next      = 1'b0;
            end else begin
                drain_idx_next = drain_idx_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            col_idx_reg   <= '0;
            row_idx_reg   <= '0;
            drain_idx_reg <= '0;
            full_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_idx_reg   <= col_idx_next;
            row_idx_reg   <= row_idx_next;
            drain_idx_reg <= drain_idx_next;
            full_reg      <= full_next;
        end
    end

    // capture the item and the neighbours as they come out of the store
    always_ff @(posedge aclk) begin
        if (start_job) begin
            is_drain_reg <= !is_push;
            pos_reg      <= s_tdata;
            jr_reg       <= is_push ? row_idx_reg - 12'd1 : row_idx_reg;
            jc_reg       <= is_push ? col_idx_reg : drain_idx_reg;
        end
        if (state_reg == F_RR) c_reg <= rdata_reg;
        if (state_reg == F_RL) r_reg <= rdata_reg;
        if (state_reg == F_RU) l_reg <= rdata_reg;
    end

    // line store
    always_ff @(posedge aclk) begin
        if (mem_we) mem[waddr] <= wdata;
        if (mem_re) rdata_reg <= mem[raddr];
    end

    always_comb begin
        job.row   = jr_reg;
        job.col   = jc_reg;
        job.last  = is_drain_reg && drain_last;
        job.has_r = ({1'b0, jc_reg} + 9'd1) < cols_eff;
        job.has_l = (jc_reg != '0);
        job.has_d = !is_drain_reg;
        job.has_u = (jr_reg != '0);
        job.c     = c_reg;
        job.r     = r_reg;
        job.l     = l_reg;
        job.d     = pos_reg;
        job.u     = rdata_reg;
    end

`ifndef SYNTHESIS
    a_full_col: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> col_idx_reg == '0)
        else $error("column index not cleared while grid is full");
    a_fin_only: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we && state_reg != F_IDLE |-> state_reg == F_FIN && !is_drain_reg)
        else $error("store written outside a push");
`endif

endmodule

`default_nettype wire

[src/gvns_queue.sv]
`default_nettype none

module gvns_queue import gvns_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  job_t      in_job,
    input  wire logic in_valid,
    output logic      in_ready,
    output job_t      out_job,
    output logic      out_valid,
    input  wire logic out_ready
);

    job_t       ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) ent_reg[wr_ptr_reg] <= in_job;
    end

    // advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

`ifndef SYNTHESIS
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("queue overfilled");
`endif

endmodule

`default_nettype wire

[src/gvns_back.sv]
`default_nettype none

module gvns_back import gvns_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  job_t             job,
    input  wire logic        job_valid,
    output logic             job_ready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,
    output logic             m_tlast
);

    back_state_t state_reg, state_next;

    job_t                job_reg;
    logic signed [30:0]  a_reg [3];
    logic signed [30:0]  b_reg [3];
    logic signed [61:0]  prod_reg;
    logic signed [62:0]  s_reg [3];
    logic [61:0]         mag_reg [3];
    logic                neg_reg [3];
    logic [61:0]         m_reg;
    logic [59:0]         sq_reg;
    logic [63:0]         len2_reg;
    logic [63:0]         x_reg, res_reg, bit_reg;
    logic [31:0]         len_reg;
    logic [5:0]          cnt_reg;
    logic [1:0]          comp_reg;
    logic [32:0]         rem_reg;
    logic [15:0]         num_reg, q_reg;
    logic signed [15:0]  nrm_reg [3];
    logic                m_tvalid_reg;
    logic [71:0]         m_tdata_reg;
    logic                m_tlast_reg;

    function automatic logic signed [29:0] nbr(pos_t n, pos_t c, logic ok);
        logic signed [32:0] d;
        d = {n[31], n} - {c[31], c};
        return ok ? 30'(d >>> 3) : '0;
    endfunction

    // stencil vectors R - L and D - U
    logic signed [29:0] rv [3], lv [3], dv [3], uv [3];
    always_comb begin
        rv[0] = nbr(job_reg.r.x, job_reg.c.x, job_reg.has_r);
        rv[1] = nbr(job_reg.r.y, job_reg.c.y, job_reg.has_r);
        rv[2] = nbr(job_reg.r.z, job_reg.c.z, job_reg.has_r);
        lv[0] = nbr(job_reg.l.x, job_reg.c.x, job_reg.has_l);
        lv[1] = nbr(job_reg.l.y, job_reg.c.y, job_reg.has_l);
        lv[2] = nbr(job_reg.l.z, job_reg.c.z, job_reg.has_l);
        dv[0] = nbr(job_reg.d.x, job_reg.c.x, job_reg.has_d);
        dv[1] = nbr(job_reg.d.y, job_reg.c.y, job_reg.has_d);
        dv[2] = nbr(job_reg.d.z, job_reg.c.z, job_reg.has_d);
        uv[0] = nbr(job_reg.u.x, job_reg.c.x, job_reg.has_u);
        uv[1] = nbr(job_reg.u.y, job_reg.c.y, job_reg.has_u);
        uv[2] = nbr(job_reg.u.z, job_reg.c.z, job_reg.has_u);
    end

    // operand select for the shared multiplier
    logic signed [30:0] op_a, op_b;
    logic signed [61:0] mul;
    logic [2:0]         acc_k;
    always_comb begin
        case (cnt_reg[2:0])
            3'd0:    begin op_a = a_reg[1]; op_b = b_reg[2]; end
            3'd1:    begin op_a = a_reg[2]; op_b = b_reg[1]; end
            3'd2:    begin op_a = a_reg[2]; op_b = b_reg[0]; end
            3'd3:    begin op_a = a_reg[0]; op_b = b_reg[2]; end
            3'd4:    begin op_a = a_reg[0]; op_b = b_reg[1]; end
            default: begin op_a = a_reg[1]; op_b = b_reg[0]; end
        endcase
        mul   = op_a * op_b;
        acc_k = 3'(cnt_reg - 6'd1);
    end

    // magnitudes and the largest one
    logic [61:0] mag_c [3];
    logic [61:0] m_c;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_c[i] = s_reg[i][62] ? 62'(-s_reg[i]) : 62'(s_reg[i]);
        end
        m_c = mag_c[0];
        if (mag_c[1] > m_c) m_c = mag_c[1];
        if (mag_c[2] > m_c) m_c = mag_c[2];
    end

    // one square root step
    logic [63:0] sq_t;
    assign sq_t = res_reg + bit_reg;

    // one divider step, quotient saturate and the rounded dividend
    logic [32:0] div_t;
    logic        div_ge;
    logic [15:0] q_new, q_sat;
    logic [44:0] numer;
    always_comb begin
        div_t  = {rem_reg[31:0], num_reg[15]};
        div_ge = div_t >= {1'b0, len_reg};
        q_new  = {q_reg[14:0], div_ge};
        q_sat  = (q_new > 16'(UNIT)) ? 16'(UNIT) : q_new;
        numer  = {1'b0, mag_reg[comp_reg][29:0], 14'd0} + 45'(res_reg[31:0] >> 1);
    end

    assign job_ready = (state_reg == B_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (job_valid) state_next = B_VEC;
            B_VEC:   state_next = B_MUL;
            B_MUL:   if (cnt_reg == 6'd6) state_next = B_MAG;
            B_MAG:   state_next = B_SCALE;
            B_SCALE: begin
                if (m_reg == '0) state_next = B_OUT;
                else if (m_reg[61:30] == '0 && m_reg[29]) state_next = B_SQ;
            end
            B_SQ:    if (cnt_reg == 6'd3) state_next = B_SQRT;
            B_SQRT:  if (cnt_reg == 6'd31) state_next = B_DSET;
            B_DSET:  state_next = B_DIV;
            B_DIV: begin
                if (cnt_reg == 6'd15) state_next = (comp_reg == 2'd2) ? B_OUT : B_DSET;
            end
            B_OUT:   if (!m_tvalid_reg || m_tready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_OUT && (!m_tvalid_reg || m_tready)) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                job_reg <= job;
                cnt_reg <= '0;
            end
            B_VEC: begin
                for (int i = 0; i < 3; i++) begin
                    a_reg[i] <= 31'(rv[i]) - 31'(lv[i]);
                    b_reg[i] <= 31'(dv[i]) - 31'(uv[i]);
                end
                cnt_reg <= '0;
            end
            B_MUL: begin
                prod_reg <= mul;
                if (cnt_reg != '0) begin
                    if (!acc_k[0]) s_reg[acc_k[2:1]] <= 63'(prod_reg);
                    else s_reg[acc_k[2:1]] <= s_reg[acc_k[2:1]] - 63'(prod_reg);
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            B_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= mag_c[i];
                    neg_reg[i] <= s_reg[i][62];
                    nrm_reg[i] <= '0;
                end
                m_reg <= m_c;
            end
            B_SCALE: begin
                // scale until the largest magnitude is in [2^29, 2^30)
                if (m_reg[61:30] != '0) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    m_reg <= m_reg >> 1;
                end else if (!m_reg[29]) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    m_reg <= m_reg << 1;
                end
                cnt_reg  <= '0;
                len2_reg <= '0;
            end
            B_SQ: begin
                if (cnt_reg != 6'd3) sq_reg <= mag_reg[cnt_reg[1:0]][29:0]
                                             * mag_reg[cnt_reg[1:0]][29:0];
                if (cnt_reg != '0) len2_reg <= len2_reg + 64'(sq_reg);
                if (cnt_reg == 6'd3) begin
                    x_reg   <= len2_reg + 64'(sq_reg);
                    res_reg <= '0;
                    bit_reg <= 64'd1 << 62;
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            B_SQRT: begin
                if (x_reg >= sq_t) begin
                    x_reg   <= x_reg - sq_t;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                cnt_reg  <= cnt_reg + 6'd1;
                comp_reg <= '0;
            end
            B_DSET: begin
                if (comp_reg == '0) len_reg <= res_reg[31:0];
                // load the dividend in the state before each component's division
                rem_reg <= {4'd0, numer[44:16]};
                num_reg <= numer[15:0];
                cnt_reg <= '0;
                q_reg   <= '0;
            end
            B_DIV: begin
                rem_reg <= div_ge ? div_t - {1'b0, len_reg} : div_t;
                num_reg <= num_reg << 1;
                q_reg   <= q_new;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd15) begin
                    nrm_reg[comp_reg] <= neg_reg[comp_reg] ? -$signed(q_sat) : $signed(q_sat);
                    comp_reg          <= comp_reg + 2'd1;
                end
            end
            B_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= {4'd0, job_reg.col, job_reg.row,
                                    nrm_reg[2], nrm_reg[1], nrm_reg[0]};
                    m_tlast_reg <= job_reg.last;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_len_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_DIV |-> len_reg >= 32'd536870912)
        else $error("length below scaled range");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> $signed(m_tdata_reg[15:0]) <= 16'sd16384
                      && $signed(m_tdata_reg[15:0]) >= -16'sd16384)
        else $error("normal component out of range");
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && job_ready |=> state_reg == B_VEC)
        else $error("job taken without starting");
`endif

endmodule

`default_nettype wire

[src/grid_vertex_normal_stencil.sv]
`default_nettype none

// Grid vertex normal stencil. Push vertex positions (Q16.16) in raster order
// with s_tuser low; the normal (Q1.14) of vertex (r, c) comes out when vertex
// (r + 1, c) is pushed, and the last row is read out by drain transactions
// (s_tuser high), one per column, the final one flagged by m_tlast. A first
// row push is only stored; every other push or drain makes the front do
// four line store reads through its single read port, and the back unit
// then runs its shared multiplier (six cross product terms), a second
// multiplier for the three square terms, a 32-step square root and a
// 16-step divider run once per component; a zero sum skips to the output.
// A two-entry job queue sits between the front and the back. Pushes after
// a full grid and drains without one are dropped.
module grid_vertex_normal_stencil import gvns_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        s_tuser,   // action
    input  wire logic [95:0] s_tdata,   // pos_x, pos_y, pos_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // normal_x, normal_y, normal_z, out_row, out_column
    output logic             m_tlast    // last_normal
);

    job_t fq_job, qb_job;
    logic fq_valid, fq_ready, qb_valid, qb_ready;

    gvns_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .job       (fq_job),
        .job_valid (fq_valid),
        .job_ready (fq_ready)
    );

    gvns_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_job    (fq_job),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .out_job   (qb_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready)
    );

    gvns_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (qb_job),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
